### sv/raam_pkg.sv
// raam_pkg: shared types, sizes and constants of the range add arg-minimum block
// used by raam_cell, raam_collect and range_add_argmin_tree
// no dependencies
package raam_pkg;

  // array size and its split over the cell chain
  localparam int MAX_POSITIONS = 1024;
  localparam int N_CELLS       = 32;
  localparam int DEPTH         = MAX_POSITIONS / N_CELLS;
  localparam int CELL_W        = $clog2(N_CELLS);
  localparam int ADDR_W        = $clog2(DEPTH);

  // field widths
  localparam int POS_W = 11;
  localparam int VAL_W = 48;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0]        pos_t;

  localparam val_t VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam pos_t POS_ONE  = pos_t'(1);
  localparam pos_t POS_LAST = pos_t'(MAX_POSITIONS);

  // input transaction payload
  typedef struct packed {
    logic [POS_W-1:0]        range_low;
    logic [POS_W-1:0]        range_high;
    logic signed [VAL_W-1:0] delta;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    logic [POS_W-1:0]        min_position;
  } out_item_t;

  // one column step of an add, handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] addr;
    pos_t              lo;
    pos_t              hi;
    val_t              delta;
  } cmd_t;

  // running minimum of one column, handed from cell to cell
  typedef struct packed {
    logic has;
    val_t val;
    pos_t pos;
  } tok_t;

  // clearing pass after reset, broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } clr_t;

endpackage

### sv/raam_cell.sv
// raam_cell: one cell of the chain, holds one position of every column
// in a small memory and folds its value into the passing column minimum
// depends on raam_pkg
module raam_cell import raam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CELL_W-1:0] cell_idx_i,
  input  pos_t              n_pos_i,
  input  clr_t              clr_i,
  input  cmd_t              cmd_i,
  input  tok_t              tok_i,
  output cmd_t              cmd_o,
  output tok_t              tok_o
);

  val_t mem [DEPTH];
  val_t rd_q;
  cmd_t cmd_q;
  tok_t tok_q, tok_d;

  logic signed [VAL_W:0] sum;
  val_t sat, nv;
  pos_t pos;
  logic in_rng, in_use;

  // command stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i;
    end
  end

  // memory read and write-back
  always_ff @(posedge clk_i) begin
    rd_q <= mem[cmd_i.addr];
    if (clr_i.en) begin
      mem[clr_i.addr] <= '0;
    end else if (cmd_q.valid) begin
      mem[cmd_q.addr] <= nv;
    end
  end

  // saturating add for positions inside the range
  always_comb begin
    pos    = pos_t'({cmd_q.addr, cell_idx_i}) + POS_ONE;
    in_rng = (pos >= cmd_q.lo) && (pos <= cmd_q.hi);
    in_use = pos <= n_pos_i;
    sum    = {rd_q[VAL_W-1], rd_q} + {cmd_q.delta[VAL_W-1], cmd_q.delta};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      sat = sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sat = sum[VAL_W-1:0];
    end
    nv = in_rng ? sat : rd_q;
  end

  // fold into the column minimum, earlier positions win ties
  always_comb begin
    tok_d = tok_i;
    if (cmd_q.valid && in_use && (!tok_i.has || (nv < tok_i.val))) begin
      tok_d.has = 1'b1;
      tok_d.val = nv;
      tok_d.pos = pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign cmd_o = cmd_q;
  assign tok_o = tok_q;

endmodule

### sv/raam_collect.sv
// raam_collect: merges the column minima at the end of the chain into the
// minimum of one add and queues results in a two-entry buffer
// depends on raam_pkg
module raam_collect import raam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  tok_t      tok_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic col_vld_q, col_first_q, col_last_q;
  val_t acc_val_q, acc_val_d;
  pos_t acc_pos_q, acc_pos_d;
  logic take;

  out_item_t fifo_q [2];
  logic      wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic      push, pop;

  // align the column flags with the registered column minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q   <= 1'b0;
      col_first_q <= 1'b0;
      col_last_q  <= 1'b0;
    end else begin
      col_vld_q   <= cmd_i.valid;
      col_first_q <= cmd_i.first;
      col_last_q  <= cmd_i.last;
    end
  end

  // columns arrive in ascending position order, strict compare keeps the lowest
  always_comb begin
    take      = col_first_q || (tok_i.has && (tok_i.val < acc_val_q));
    acc_val_d = take ? tok_i.val : acc_val_q;
    acc_pos_d = take ? tok_i.pos : acc_pos_q;
  end

  always_ff @(posedge clk_i) begin
    if (col_vld_q) begin
      acc_val_q <= acc_val_d;
      acc_pos_q <= acc_pos_d;
    end
  end

  // result buffer
  assign push = col_vld_q && col_last_q;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].min_value    <= acc_val_d;
      fifo_q[wr_ptr_q].min_position <= acc_pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = fifo_q[rd_ptr_q];

endmodule

### sv/range_add_argmin_tree.sv
// range_add_argmin_tree: saturating range add of signed values over 1024 positions with
// lowest-position minimum after each add; top level with issue logic and chain
// depends on raam_pkg, raam_cell, raam_collect
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  in_data_i (range_low, range_high, delta)
//   out      output     out_valid_o/out_ready_i out_data_o (min_value, min_position)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (n_positions)
//
// an add sweeps the 32 addresses of the 32-cell chain, one address a cycle, and the
// input is ready again once the sweep reaches its last address; the column minima ripple
// through the 32 cells and are merged into the minimum of the add.
// at most two adds are outstanding, so a third waits for the first result.
// after reset a clearing pass zeroes the cell memories; no input transaction is
// taken meanwhile, configuration writes are.
// a stalled output holds results in a two-entry buffer and blocks the input.
module range_add_argmin_tree import raam_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [POS_W-1:0] cfg_data_i
);

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  pos_t n_q;
  logic clr_act_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic act_q;
  logic [ADDR_W-1:0] addr_q;
  pos_t lo_q, hi_q, lo_c, hi_c;
  val_t delta_q;
  logic [1:0] outs_q;
  logic in_acc, out_acc;
  clr_t clr;

  cmd_t cmd_w [N_CELLS+1];
  tok_t tok_w [N_CELLS+1];

  // configuration register, held clamped to 1..MAX_POSITIONS
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= POS_LAST;
    end else if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        n_q <= POS_ONE;
      end else if (cfg_data_i > POS_LAST) begin
        n_q <= POS_LAST;
      end else begin
        n_q <= cfg_data_i;
      end
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q  <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_act_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_LAST) begin
        clr_act_q <= 1'b0;
      end
    end
  end

  assign clr.en   = clr_act_q;
  assign clr.addr = clr_addr_q;

  // input acceptance and outstanding count
  assign in_ready_o = !clr_act_q && (!act_q || (addr_q == ADDR_LAST)) && (outs_q != 2'd2);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outs_q <= 2'd0;
    end else begin
      outs_q <= outs_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // range clipping to 1..n_positions
  always_comb begin
    lo_c = (in_data_i.range_low == '0) ? POS_ONE : in_data_i.range_low;
    hi_c = (in_data_i.range_high > n_q) ? n_q : in_data_i.range_high;
  end

  // address sweep of the current add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      addr_q <= '0;
    end else if (in_acc) begin
      act_q  <= 1'b1;
      addr_q <= '0;
    end else if (act_q) begin
      addr_q <= addr_q + ADDR_W'(1);
      if (addr_q == ADDR_LAST) begin
        act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lo_q    <= lo_c;
      hi_q    <= hi_c;
      delta_q <= in_data_i.delta;
    end
  end

  // head of the chain
  assign cmd_w[0].valid = act_q;
  assign cmd_w[0].first = addr_q == '0;
  assign cmd_w[0].last  = addr_q == ADDR_LAST;
  assign cmd_w[0].addr  = addr_q;
  assign cmd_w[0].lo    = lo_q;
  assign cmd_w[0].hi    = hi_q;
  assign cmd_w[0].delta = delta_q;
  assign tok_w[0]       = '0;

  // chain of cells
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    raam_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CELL_W'(k)),
      .n_pos_i    (n_q),
      .clr_i      (clr),
      .cmd_i      (cmd_w[k]),
      .tok_i      (tok_w[k]),
      .cmd_o      (cmd_w[k+1]),
      .tok_o      (tok_w[k+1])
    );
  end

  // merge of column minima and result buffer
  raam_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_w[N_CELLS]),
    .tok_i       (tok_w[N_CELLS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
